FILE: hdl/ismt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ismt_pkg: shared types and codes for the integer set membership table
// Operation codes, data widths and the control word that travels down the
// cell chain together with each transaction.
// ----------------------------------------------------------------------------
package ismt_pkg;

  // Element width and default table size
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned COUNT_OUT_W  = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  // Operation codes; the unused code behaves as a query
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Control word handed from cell to cell
  typedef struct packed {
    logic              vld;         // a transaction occupies this stage
    logic [FUNC_W-1:0] func;        // operation code
    logic              hit;         // value matched in an earlier cell
    logic              free_found;  // an earlier cell was free
  } tok_ctl_t;

endpackage : ismt_pkg
`default_nettype wire

FILE: hdl/ismt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ismt_cell: one entry of the membership table
// Holds one value and its valid mark, compares the passing transaction
// against it, notes the first free entry and forwards the transaction to the
// next cell through a register. A remove clears the entry as it passes; an add
// is committed by the top level through the write port.
// ----------------------------------------------------------------------------
module ismt_cell #(
  parameter int unsigned       IW  = 4,
  parameter logic [IW-1:0]     IDX = '0
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ismt_pkg::tok_ctl_t              tok_in,
  input  wire logic [ismt_pkg::VALUE_W-1:0]    val_in,
  input  wire logic [IW-1:0]                   fidx_in,
  output      ismt_pkg::tok_ctl_t              tok_out,
  output      logic [ismt_pkg::VALUE_W-1:0]    val_out,
  output      logic [IW-1:0]                   fidx_out,
  input  wire logic                            wr_en,
  input  wire logic [IW-1:0]                   wr_idx,
  input  wire logic [ismt_pkg::VALUE_W-1:0]    wr_value
);
  import ismt_pkg::*;

  logic [VALUE_W-1:0] ent_value;
  logic               ent_valid;
  logic               match;
  logic               wr_sel;

  assign match  = tok_in.vld && ent_valid && (ent_value == val_in);
  assign wr_sel = wr_en && (wr_idx == IDX);

  // Control stage and valid mark
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out   <= '0;
      ent_valid <= 1'b0;
    end else begin
      tok_out.vld        <= tok_in.vld;
      tok_out.func       <= tok_in.func;
      tok_out.hit        <= tok_in.hit | match;
      tok_out.free_found <= tok_in.free_found | (tok_in.vld && !ent_valid);
      if (wr_sel) begin
        ent_valid <= 1'b1;
      end else if (match && (tok_in.func == FUNC_REMOVE)) begin
        ent_valid <= 1'b0;
      end
    end
  end

  // Payload stage and stored value
  always_ff @(posedge clk) begin
    val_out  <= val_in;
    fidx_out <= (tok_in.free_found || ent_valid) ? fidx_in : IDX;
    if (wr_sel) begin
      ent_value <= wr_value;
    end
  end

endmodule : ismt_cell
`default_nettype wire

FILE: hdl/integer_set_membership_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_set_membership_table: set of signed 32-bit integers in a CAM chain
// Add, remove or query one value per transaction; each transaction returns
// whether the value was present, the element count and a table-full reject.
//
//   channel  signals                                   direction
//   input    in_valid, in_stall, func, value           into block
//   output   out_valid, out_stall, was_present,        out of block
//            element_count, full_reject
//
// A transaction walks the chain of CAPACITY cells, one cell per cycle, and
// the result is registered as it leaves the last cell. The next item is
// taken in the cycle the result appears unless the output is stalled.
// The lowest free entry is written in the cycle the transaction leaves the
// last cell. Reset clears all valid marks and the count at once.
// The input stalls while a transaction is in the chain or while a finished
// result is held under output stall.
// ----------------------------------------------------------------------------
module integer_set_membership_table #(
  parameter int unsigned CAPACITY = ismt_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic [ismt_pkg::FUNC_W-1:0]          func,
  input  wire logic signed [ismt_pkg::VALUE_W-1:0]  value,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic                                 was_present,
  output      logic [ismt_pkg::COUNT_OUT_W-1:0]     element_count,
  output      logic                                 full_reject
);
  import ismt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [CW+COUNT_OUT_W-1:0] cnt_ext;
  logic               in_acc;

  tok_ctl_t           tok_c  [CAPACITY+1];
  logic [VALUE_W-1:0] val_c  [CAPACITY+1];
  logic [IW-1:0]      fidx_c [CAPACITY+1];

  tok_ctl_t           last;
  logic               is_add;
  logic               commit_add;
  logic               reject;
  logic               dec;

  // Input handshake
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // Chain entry
  assign tok_c[0]  = '{vld: in_acc, func: func, hit: 1'b0, free_found: 1'b0};
  assign val_c[0]  = $unsigned(value);
  assign fidx_c[0] = '0;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ismt_cell #(
      .IW  (IW),
      .IDX (IW'(i))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_c[i]),
      .val_in   (val_c[i]),
      .fidx_in  (fidx_c[i]),
      .tok_out  (tok_c[i+1]),
      .val_out  (val_c[i+1]),
      .fidx_out (fidx_c[i+1]),
      .wr_en    (commit_add),
      .wr_idx   (fidx_c[CAPACITY]),
      .wr_value (val_c[CAPACITY])
    );
  end

  // Commit when the transaction leaves the last cell
  assign last       = tok_c[CAPACITY];
  assign is_add     = last.vld && (last.func == FUNC_ADD) && !last.hit;
  assign commit_add = is_add && last.free_found;
  assign reject     = is_add && !last.free_found;
  assign dec        = last.vld && (last.func == FUNC_REMOVE) && last.hit;

  always_comb begin
    cnt_next = cnt;
    if (commit_add) begin
      cnt_next = cnt + CW'(1);
    end else if (dec) begin
      cnt_next = cnt - CW'(1);
    end
  end

  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_next};

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc)   state_next = ST_RUN;
      ST_RUN:  if (last.vld) state_next = ST_IDLE;
      default:               state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (last.vld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (last.vld) begin
      was_present   <= last.hit;
      element_count <= cnt_ext[COUNT_OUT_W-1:0];
      full_reject   <= reject;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RUN))
    else $error("result produced without a transaction in the chain");

  a_reject_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(full_reject && was_present))
    else $error("reject flagged for a present value");

  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> in_stall)
    else $error("input open while chain is busy");
`endif

endmodule : integer_set_membership_table
`default_nettype wire

FILE: test/tb_integer_set_membership_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_integer_set_membership_table: self-checking bench for the CAM set table
// Drives add, remove and query transactions from a pending queue. A local
// copy of the table predicts was_present, element_count and full_reject for
// each accepted transaction, and each accepted result is compared with the
// oldest prediction. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_integer_set_membership_table;
  import ismt_pkg::*;

  localparam int unsigned TABLE_DEPTH = CAPACITY_DEF;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;  // unused code, acts as query
  localparam int unsigned BATCH_ITEMS = 100;
  localparam int unsigned BATCH_COUNT = 12;
  localparam int unsigned TAIL_ITEMS  = 150;
  localparam int unsigned POOL_SIZE   = 24;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
  } set_op_t;

  typedef struct packed {
    logic                   was_present;
    logic [COUNT_OUT_W-1:0] element_count;
    logic                   full_reject;
  } set_res_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [FUNC_W-1:0]            func = FUNC_QUERY;
  logic signed [VALUE_W-1:0]    value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         was_present;
  logic [COUNT_OUT_W-1:0]       element_count;
  logic                         full_reject;

  // Shadow copy of the table
  logic [VALUE_W-1:0] shadow_val [TABLE_DEPTH];
  bit                 shadow_vld [TABLE_DEPTH];
  logic [8:0]         shadow_cnt;

  set_op_t   pending_ops [$];
  set_res_t  expected_res [$];
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];

  int unsigned issued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt   = 0;
  int unsigned error_cnt    = 0;
  int unsigned hit_cnt      = 0;
  int unsigned reject_cnt   = 0;
  int unsigned full_cnt     = 0;
  int unsigned empty_cnt    = 0;
  int unsigned idle_left    = 0;
  int unsigned stall_left   = 0;
  bit          random_loaded = 1'b0;

  integer_set_membership_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .was_present  (was_present),
    .element_count(element_count),
    .full_reject  (full_reject)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow table and return the expected result
  function automatic set_res_t apply_set_op(input set_op_t op);
    set_res_t r;
    int hit;
    int slot;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && shadow_vld[i] && shadow_val[i] == op.value) hit = i;
      if (slot < 0 && !shadow_vld[i]) slot = i;
    end
    r.was_present = (hit >= 0);
    r.full_reject = 1'b0;
    case (op.func)
      FUNC_ADD: begin
        if (hit < 0) begin
          if (slot < 0) begin
            r.full_reject = 1'b1;
          end else begin
            shadow_val[slot] = op.value;
            shadow_vld[slot] = 1'b1;
            shadow_cnt++;
          end
        end
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          shadow_vld[hit] = 1'b0;
          shadow_cnt--;
        end
      end
      default: ;
    endcase
    r.element_count = shadow_cnt[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic void queue_op(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
    set_op_t op;
    op.func  = f;
    op.value = v;
    pending_ops = {pending_ops, op};
  endfunction

  // No idling once the run is near its end
  function automatic bit in_tail();
    return random_loaded && (pending_ops.size() < TAIL_ITEMS);
  endfunction

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin : watch
    set_op_t  op;
    set_res_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        op.func  = func;
        op.value = value;
        want = apply_set_op(op);
        expected_res = {expected_res, want};
        accepted_cnt++;
        if (want.was_present) hit_cnt++;
        if (want.full_reject) reject_cnt++;
        if (shadow_cnt == TABLE_DEPTH) full_cnt++;
        if (shadow_cnt == 0) empty_cnt++;
      end
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (expected_res.size() == 0) begin
          $error("result with no transaction outstanding");
          error_cnt++;
        end else begin
          want = expected_res.pop_front();
          if (was_present !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present, was_present);
            error_cnt++;
          end
          if (element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d", want.element_count,
                   element_count);
            error_cnt++;
          end
          if (full_reject !== want.full_reject) begin
            $error("full_reject: expected %0d, got %0d", want.full_reject, full_reject);
            error_cnt++;
          end
        end
      end
    end
  end

  // Driver: hold a transaction until taken, otherwise idle or send the next
  always @(negedge clk) begin : drive
    set_op_t nx;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted_cnt != issued_cnt) begin
      // payload held while stalled
    end else if (idle_left > 0) begin
      idle_left--;
      in_valid <= 1'b0;
    end else if (pending_ops.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
      idle_left = $urandom_range(1, 6) - 1;
      in_valid <= 1'b0;
    end else begin
      nx = pending_ops.pop_front();
      func     <= nx.func;
      value    <= nx.value;
      in_valid <= 1'b1;
      issued_cnt++;
    end
  end

  // Output stall in random bursts
  always @(negedge clk) begin
    if (rst || in_tail()) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned r;
    logic [FUNC_W-1:0] f;
    logic [VALUE_W-1:0] v;
    bit add_heavy;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_val[i] = '0;
      shadow_vld[i] = 1'b0;
    end
    shadow_cnt = '0;
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme values, every code, duplicate add, absent remove,
    // then fill the table and add into a full table
    queue_op(FUNC_ADD, 32'h8000_0000);
    queue_op(FUNC_ADD, 32'h7fff_ffff);
    queue_op(FUNC_ADD, 32'h0000_0000);
    queue_op(FUNC_ADD, 32'hffff_ffff);
    queue_op(FUNC_ADD, 32'h7fff_ffff);
    queue_op(FUNC_QUERY, 32'h8000_0000);
    queue_op(FUNC_SPARE, 32'h0000_0000);
    queue_op(FUNC_QUERY, 32'h0000_0005);
    queue_op(FUNC_REMOVE, 32'hffff_ffff);
    queue_op(FUNC_REMOVE, 32'hffff_ffff);
    for (int i = 0; i < 13; i++) queue_op(FUNC_ADD, 32'h1 << i);
    queue_op(FUNC_ADD, 32'h1234_5678);
    queue_op(FUNC_ADD, 32'h7fff_ffff);

    // Hold off until the directed part has fully drained
    while (pending_ops.size() > 0 || accepted_cnt != issued_cnt ||
           expected_res.size() > 0) @(posedge clk);

    // Random: batches alternate between draining and filling the table
    for (int b = 0; b < BATCH_COUNT; b++) begin
      add_heavy = b[0];
      for (int k = 0; k < BATCH_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < (add_heavy ? 55 : 25))      f = FUNC_ADD;
        else if (r < 80)                    f = FUNC_REMOVE;
        else if (r < 94)                    f = FUNC_QUERY;
        else                                f = FUNC_SPARE;
        if ($urandom_range(0, 99) < 85) v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else                            v = $urandom();
        queue_op(f, v);
      end
    end
    random_loaded = 1'b1;

    while (pending_ops.size() > 0 || accepted_cnt != issued_cnt) @(posedge clk);
    while (expected_res.size() > 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("%0d transactions, %0d results: %0d hits, %0d full rejects,",
             accepted_cnt, result_cnt, hit_cnt, reject_cnt);
    $display("table seen full %0d times and empty %0d times", full_cnt, empty_cnt);
    if (error_cnt == 0) begin
      $display("tb_integer_set_membership_table: done, clean");
    end else begin
      $display("tb_integer_set_membership_table: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_integer_set_membership_table: done, errors");
    $finish;
  end

endmodule : tb_integer_set_membership_table
`default_nettype wire
